@@ rtl/chol_pkg.sv @@
// ----------------------------------------------------------------------------
// chol_pkg
// Shared types and constants of the Cholesky factor unit.
// ----------------------------------------------------------------------------
package chol_pkg;
   localparam int MAX_DIM_DEF    = 8;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int IO_WIDTH       = 32;
   localparam int DIM_WIDTH      = 4;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_ROW,
      ST_DOT_RD,
      ST_DOT_MUL,
      ST_DOT_ACC,
      ST_DIAG_RD,
      ST_OP_START,
      ST_OP_WAIT,
      ST_WRITE,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_OUT_HOLD
   } state_type;

   typedef enum logic [0:0] {
      OP_SQRT,
      OP_DIV
   } op_type;
endpackage

@@ rtl/chol_arith.sv @@
// ----------------------------------------------------------------------------
// chol_arith
// Iterative square root and fixed-point divider, one step per cycle.
// ----------------------------------------------------------------------------
module chol_arith #(
   parameter int DATA_WIDTH = chol_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = chol_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  chol_pkg::op_type             op,
   input  logic signed [DATA_WIDTH-1:0] num,
   input  logic signed [DATA_WIDTH-1:0] den,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] result
);
   import chol_pkg::*;

   localparam int SW    = DATA_WIDTH + FRAC_BITS;
   localparam int SQ_ST = SW / 2;
   localparam int RW    = SW + 2;
   localparam int CW    = $clog2(SW + 1);

   logic [SW-1:0]       src_ff, src_in;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [SW-1:0]       q_ff, q_in;
   logic [DATA_WIDTH:0] dm_ff, dm_in;
   logic                neg_ff, neg_in;
   logic                zero_ff, zero_in;
   op_type              op_ff, op_in;
   logic                busy_ff, busy_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                done_ff, done_in;

   logic [DATA_WIDTH:0] nm;
   logic [RW-1:0]       rsh, trial;
   logic [SW+1:0]       srcx;
   logic [SW-1:0]       qmax;
   logic signed [DATA_WIDTH:0] sres;

   always_comb begin
      nm = num[DATA_WIDTH-1] ? -{num[DATA_WIDTH-1], num} : {num[DATA_WIDTH-1], num};
      src_in = src_ff; rem_in = rem_ff; q_in = q_ff; dm_in = dm_ff;
      neg_in = neg_ff; zero_in = zero_ff; op_in = op_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      srcx = {src_ff, 2'b00};
      rsh = '0; trial = '0;
      if (start) begin
         op_in = op; busy_in = 1'b1; rem_in = '0; q_in = '0;
         src_in = {nm[DATA_WIDTH-1:0], {FRAC_BITS{1'b0}}};
         if (op == OP_SQRT) begin
            cnt_in = CW'(SQ_ST);
            if (SW % 2 == 1) src_in = {nm[DATA_WIDTH-2:0], {FRAC_BITS{1'b0}}, 1'b0};
            dm_in = '0; neg_in = 1'b0; zero_in = 1'b0;
         end else begin
            cnt_in = CW'(SW);
            dm_in = den[DATA_WIDTH-1] ? -{den[DATA_WIDTH-1], den} : {den[DATA_WIDTH-1], den};
            neg_in = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
            zero_in = (den == '0);
         end
      end else if (busy_ff) begin
         if (op_ff == OP_SQRT) begin
            rsh = {rem_ff[RW-3:0], src_ff[SW-1:SW-2]};
            trial = RW'({q_ff, 2'b01});
            src_in = srcx[SW-1:0];
            if (rsh >= trial) begin
               rem_in = rsh - trial; q_in = {q_ff[SW-2:0], 1'b1};
            end else begin
               rem_in = rsh; q_in = {q_ff[SW-2:0], 1'b0};
            end
         end else begin
            rsh = {rem_ff[RW-2:0], src_ff[SW-1]};
            src_in = {src_ff[SW-2:0], 1'b0};
            if (rsh >= RW'(dm_ff)) begin
               rem_in = rsh - RW'(dm_ff); q_in = {q_ff[SW-2:0], 1'b1};
            end else begin
               rem_in = rsh; q_in = {q_ff[SW-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in; rem_ff <= rem_in; q_ff <= q_in; dm_ff <= dm_in;
      neg_ff <= neg_in; zero_ff <= zero_in; op_ff <= op_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   always_comb begin
      qmax = SW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
      sres = '0;
      if (zero_ff && op_ff == OP_DIV) begin
         sres = '0;
      end else if (neg_ff) begin
         if (q_ff > qmax) sres = {1'b1, 1'b1, {(DATA_WIDTH-1){1'b0}}};
         else sres = -$signed({1'b0, q_ff[DATA_WIDTH-1:0]});
      end else begin
         if (q_ff > qmax) sres = $signed({1'b0, qmax[DATA_WIDTH-1:0]});
         else sres = $signed({1'b0, q_ff[DATA_WIDTH-1:0]});
      end
   end

   assign done   = done_ff;
   assign result = sres[DATA_WIDTH-1:0];
endmodule

@@ rtl/chol_mac.sv @@
// ----------------------------------------------------------------------------
// chol_mac
// Saturating fixed-point product, registered, for the dot-product sum.
// ----------------------------------------------------------------------------
module chol_mac #(
   parameter int DATA_WIDTH = chol_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = chol_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic signed [DATA_WIDTH-1:0] x,
   input  logic signed [DATA_WIDTH-1:0] y,
   output logic signed [DATA_WIDTH-1:0] prod
);
   import chol_pkg::*;

   localparam int PW = 2 * DATA_WIDTH;

   logic [DATA_WIDTH-1:0]      xm, ym;
   logic [PW-1:0]              pm_ff, pm_in;
   logic                       neg_ff, neg_in;
   logic [PW-1:0]              sh;
   logic [PW-1:0]              vmax;
   logic signed [DATA_WIDTH:0] r;

   always_comb begin
      xm = x[DATA_WIDTH-1] ? DATA_WIDTH'(-x) : DATA_WIDTH'(x);
      ym = y[DATA_WIDTH-1] ? DATA_WIDTH'(-y) : DATA_WIDTH'(y);
      pm_in  = PW'(xm) * PW'(ym);
      neg_in = x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      pm_ff  <= pm_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      sh   = pm_ff >> FRAC_BITS;
      vmax = PW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
      if (neg_ff) begin
         if (sh > vmax) r = {1'b1, 1'b1, {(DATA_WIDTH-1){1'b0}}};
         else r = -$signed({1'b0, sh[DATA_WIDTH-1:0]});
      end else begin
         if (sh > vmax) r = $signed({1'b0, vmax[DATA_WIDTH-1:0]});
         else r = $signed({1'b0, sh[DATA_WIDTH-1:0]});
      end
   end

   assign prod = r[DATA_WIDTH-1:0];
endmodule

@@ rtl/cholesky_decomposition.sv @@
// ----------------------------------------------------------------------------
// cholesky_decomposition
// Loads a symmetric Q16.16 matrix and streams out its lower Cholesky factor.
// ----------------------------------------------------------------------------
// channel  dir  beat
// req_     in   a_value
// rsp_     out  l_value, is_last and not_pos_def
// csr_     in   dim
// Load beats are taken while req_tvalid is high, then all MAX_DIM*MAX_DIM l_mem
// entries are cleared. Each factor element takes its control states, a read,
// multiply and accumulate step per dot-product term via the one multiplier,
// and a root or divide in the shared unit. Output reads and holds each
// beat until the sink takes it. Reset is synchronous; no req_ beat is taken from
// the last load beat until the last output beat is taken; csr_ready stays high.
module cholesky_decomposition
   import chol_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [IO_WIDTH-1:0]  req_tdata,   // a_value
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [IO_WIDTH-1:0]  rsp_tdata,   // l_value
   output logic                 rsp_tlast,   // is_last
   output logic                 rsp_tuser,   // not_pos_def
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_data     // dim in bits 3:0
);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(MAX_DIM + 1);
   localparam int SUMW  = DATA_WIDTH + 4;

   state_type state_ff, state_in;
   logic [DIM_WIDTH-1:0] dim_ff;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [KW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [SUMW-1:0] s_ff, s_in;
   logic signed [DATA_WIDTH-1:0] ta_ff, ta_in, diag_ff, diag_in, diff_ff, diff_in;
   logic err_ff, err_in;
   logic [KW-1:0] n;
   logic [AW:0]   total;

   logic signed [DATA_WIDTH-1:0] a_mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] l_mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] a_rd_ff, l_rd0_ff, l_rd1_ff;
   logic [AW-1:0] a_ra, l_ra0, l_ra1, l_wa, a_wa;
   logic          l_we, a_we;
   logic signed [DATA_WIDTH-1:0] l_wd, a_wd, prod, op_res;
   logic op_start, op_done;
   op_type op_sel;
   logic signed [IO_WIDTH-1:0] outv_ff, outv_in;
   logic signed [IO_WIDTH-1:0] rv;
   logic signed [SUMW-1:0] dsum;
   logic go_ff;

   always_comb begin
      if (dim_ff == '0) n = KW'(1);
      else if (32'(dim_ff) > MAX_DIM) n = KW'(MAX_DIM);
      else n = KW'(dim_ff);
      total = (AW+1)'(n) * (AW+1)'(n);
   end

   always_comb begin
      rv = $signed(req_tdata);
      if (DATA_WIDTH >= IO_WIDTH) a_wd = DATA_WIDTH'(rv);
      else if (rv > $signed(IO_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}})))
         a_wd = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      else if (rv < -$signed(IO_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}})) - 1)
         a_wd = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else a_wd = DATA_WIDTH'(rv);
   end

   always_ff @(posedge clock) begin
      if (a_we) a_mem[a_wa] <= a_wd;
      a_rd_ff <= a_mem[a_ra];
      if (l_we) l_mem[l_wa] <= l_wd;
      l_rd0_ff <= l_mem[l_ra0];
      l_rd1_ff <= l_mem[l_ra1];
   end

   chol_mac #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac (
      .clock(clock), .x(l_rd0_ff), .y(l_rd1_ff), .prod(prod));

   chol_arith #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_arith (
      .clock(clock), .reset(reset), .start(op_start), .op(op_sel),
      .num(diff_ff), .den(diag_ff), .done(op_done), .result(op_res));

   always_comb begin
      dsum = $signed(SUMW'(a_rd_ff)) - s_ff;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      s_in = s_ff; ta_in = ta_ff; diag_in = diag_ff; diff_in = diff_ff;
      err_in = err_ff; outv_in = outv_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff + 1'b1 >= total) begin
                  cnt_in = '0; state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff + 1'b1 >= (AW+1)'(DEPTH)) begin
               cnt_in = '0; i_in = '0; j_in = '0; state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            k_in = '0; s_in = '0;
            state_in = (j_ff == '0) ? ST_DIAG_RD : ST_DOT_RD;
         end
         ST_DOT_RD: state_in = ST_DOT_MUL;
         ST_DOT_MUL: state_in = ST_DOT_ACC;
         ST_DOT_ACC: begin
            s_in = s_ff + SUMW'(prod);
            k_in = k_ff + 1'b1;
            state_in = (k_ff + 1'b1 == j_ff) ? ST_DIAG_RD : ST_DOT_RD;
         end
         ST_DIAG_RD: state_in = ST_OP_START;
         ST_OP_START: begin
            diag_in = l_rd0_ff;
            if (dsum > $signed(SUMW'({1'b0, {(DATA_WIDTH-1){1'b1}}})))
               diff_in = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            else if (dsum < -$signed(SUMW'({1'b0, {(DATA_WIDTH-1){1'b1}}})) - 1)
               diff_in = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            else diff_in = DATA_WIDTH'(dsum);
            state_in = ST_OP_WAIT;
         end
         ST_OP_WAIT: begin
            if (op_done) begin
               ta_in = op_res;
               if (i_ff == j_ff && diff_ff <= 0) begin
                  ta_in = '0; err_in = 1'b1;
               end
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (j_ff == i_ff) begin
               j_in = '0; i_in = i_ff + 1'b1;
               if (i_ff + 1'b1 == n) begin
                  cnt_in = '0; state_in = ST_OUT_RD;
               end else state_in = ST_ROW;
            end else begin
               j_in = j_ff + 1'b1; state_in = ST_ROW;
            end
         end
         ST_OUT_RD: state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: begin
            if (DATA_WIDTH <= IO_WIDTH) outv_in = IO_WIDTH'(l_rd0_ff);
            else if (l_rd0_ff > $signed(DATA_WIDTH'({1'b0, {(IO_WIDTH-1){1'b1}}})))
               outv_in = {1'b0, {(IO_WIDTH-1){1'b1}}};
            else if (l_rd0_ff < -$signed(DATA_WIDTH'({1'b0, {(IO_WIDTH-1){1'b1}}})) - 1)
               outv_in = {1'b1, {(IO_WIDTH-1){1'b0}}};
            else outv_in = IO_WIDTH'(l_rd0_ff);
            state_in = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            if (rsp_tready) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff + 1'b1 == total) begin
                  cnt_in = '0; state_in = ST_LOAD;
               end else state_in = ST_OUT_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      a_we = (state_ff == ST_LOAD) && req_tvalid && (cnt_ff < (AW+1)'(DEPTH));
      a_wa = cnt_ff[AW-1:0];
      a_ra = AW'(32'(i_ff) * 32'(n) + 32'(j_ff));
      l_ra0 = AW'(32'(i_ff) * 32'(n) + 32'(k_ff));
      l_ra1 = AW'(32'(j_ff) * 32'(n) + 32'(k_ff));
      l_we = 1'b0; l_wa = AW'(32'(i_ff) * 32'(n) + 32'(j_ff)); l_wd = ta_ff;
      op_sel = (i_ff == j_ff) ? OP_SQRT : OP_DIV;
      unique case (state_ff)
         ST_CLEAR: begin
            l_we = 1'b1; l_wa = cnt_ff[AW-1:0]; l_wd = '0;
         end
         ST_DIAG_RD: l_ra0 = AW'(32'(j_ff) * 32'(n) + 32'(j_ff));
         ST_WRITE: l_we = 1'b1;
         ST_OUT_RD: l_ra0 = cnt_ff[AW-1:0];
         default: l_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) go_ff <= 1'b0;
      else go_ff <= (state_ff == ST_OP_START);
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in; ta_ff <= ta_in; diag_ff <= diag_in; diff_ff <= diff_in;
      outv_ff <= outv_in; i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      if (reset) begin
         state_ff <= ST_LOAD; cnt_ff <= '0; err_ff <= 1'b0;
         dim_ff <= DIM_WIDTH'(8);
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; err_ff <= err_in;
         if (csr_valid) dim_ff <= csr_data[DIM_WIDTH-1:0];
      end
   end

   assign op_start = go_ff && (state_ff == ST_OP_WAIT);

   assign req_tready = (state_ff == ST_LOAD);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == ST_OUT_HOLD);
   assign rsp_tdata  = outv_ff;
   assign rsp_tlast  = (cnt_ff + 1'b1 == total);
   assign rsp_tuser  = err_ff;
endmodule
